// File: sv/sgtrs_pkg.sv
// Shared types and constants of the scatter-gather transfer request splitter.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none

package sgtrs_pkg;

   localparam int ReqDataWidth = 104;
   localparam int RspDataWidth = 168;
   localparam int CsrIndexWidth = 3;
   localparam int CsrDataWidth = 32;

   localparam logic [CsrIndexWidth-1:0] CSR_SEG_LIMIT   = 3'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_XFER_LIMIT  = 3'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_BLOCK_SHIFT = 3'd2;
   localparam logic [CsrIndexWidth-1:0] CSR_TARGET_ID   = 3'd3;
   localparam logic [CsrIndexWidth-1:0] CSR_LUN_ID      = 3'd4;

   localparam logic REQ_TYPE_START  = 1'b0;
   localparam logic REQ_TYPE_BUFFER = 1'b1;

   localparam logic [3:0] ShiftMin = 4'd9;
   localparam logic [3:0] ShiftMax = 4'd12;

   localparam logic [7:0] LunAddrMethod = 8'h01;
   localparam logic [7:0] LunHiMask     = 8'h3f;
   localparam logic [7:0] LunHiFlat     = 8'h40;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CALC,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic load_start;
      logic load_buffer;
      logic calc;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic loop_go;
      logic last;
      logic out_free;
   } status_type;

endpackage

`default_nettype wire

// File: sv/sgtrs_ctrl.sv
// Sequencing state machine of the splitter: accepts words, steps descriptors.
// Depends on sgtrs_pkg for the state, command and status types.
`default_nettype none

module sgtrs_ctrl
   import sgtrs_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   input  wire logic       req_tuser,
   output logic            req_tready,
   input  wire status_type stat,
   output cmd_type         cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               if (req_tuser == REQ_TYPE_START) begin
                  cmd.load_start = 1'b1;
               end else begin
                  cmd.load_buffer = 1'b1;
                  state_in = ST_CALC;
               end
            end
         end
         ST_CALC: begin
            if (stat.loop_go) begin
               cmd.calc = 1'b1;
               state_in = ST_EMIT;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_EMIT: begin
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               state_in = stat.last ? ST_IDLE : ST_CALC;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

`default_nettype wire

// File: sv/sgtrs_datapath.sv
// Datapath of the splitter: configuration, transfer and request state,
// descriptor length and the output register. Depends on sgtrs_pkg.
`default_nettype none

module sgtrs_datapath
   import sgtrs_pkg::*;
#(
   parameter int MAX_BUF_BLOCKS = 64
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     csr_we,
   input  wire logic [CsrIndexWidth-1:0] csr_index,
   input  wire logic [CsrDataWidth-1:0]  csr_wdata,
   input  wire logic [ReqDataWidth-1:0]  req_tdata,
   input  wire cmd_type                  cmd,
   output status_type                    stat,
   output logic                          rsp_tvalid,
   input  wire logic                     rsp_tready,
   output logic [RspDataWidth-1:0]       rsp_tdata,
   output logic                          rsp_tlast
);

   localparam logic [6:0] MaxBuf = 7'(MAX_BUF_BLOCKS);

   logic [15:0] seg_limit_ff;
   logic [31:0] xfer_limit_ff;
   logic [3:0]  block_shift_ff;
   logic [7:0]  target_id_ff;
   logic [13:0] lun_id_ff;

   logic [31:0] blocks_left_ff;
   logic [63:0] next_lba_ff;
   logic        req_open_ff;
   logic [63:0] req_first_lba_ff;
   logic [31:0] req_total_ff;
   logic [15:0] desc_in_req_ff;
   logic        write_mode_ff;
   logic [6:0]  remaining_ff;
   logic [6:0]  offset_ff;
   logic [6:0]  len_ff;
   logic [6:0]  len_in;

   logic                    rsp_valid_ff;
   logic [RspDataWidth-1:0] rsp_data_ff;
   logic                    rsp_last_ff;

   logic [63:0] in_lba;
   logic [31:0] in_count;
   logic        in_write;
   logic [6:0]  in_bufblk;

   logic [31:0] room;
   logic [6:0]  len_a;
   logic [31:0] total_n;
   logic [15:0] desc_n;
   logic [31:0] blocks_n;
   logic [6:0]  remaining_n;
   logic        close;
   logic [3:0]  shift;
   logic [17:0] off_bytes;
   logic [18:0] len_bytes;
   logic [7:0]  lun_hi;
   logic [31:0] lun_word;

   assign in_lba    = req_tdata[63:0];
   assign in_count  = req_tdata[95:64];
   assign in_write  = req_tdata[96];
   assign in_bufblk = req_tdata[103:97];

   always_ff @(posedge clock) begin
      if (reset) begin
         seg_limit_ff   <= '0;
         xfer_limit_ff  <= '0;
         block_shift_ff <= ShiftMin;
         target_id_ff   <= '0;
         lun_id_ff      <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_SEG_LIMIT:   seg_limit_ff   <= csr_wdata[15:0];
            CSR_XFER_LIMIT:  xfer_limit_ff  <= csr_wdata[31:0];
            CSR_BLOCK_SHIFT: block_shift_ff <= csr_wdata[3:0];
            CSR_TARGET_ID:   target_id_ff   <= csr_wdata[7:0];
            CSR_LUN_ID:      lun_id_ff      <= csr_wdata[13:0];
            default: ;
         endcase
      end
   end

   // Length of the next descriptor, bounded by the buffer, the transfer and
   // the room left under the request limit.
   always_comb begin
      room = (xfer_limit_ff > req_total_ff) ? xfer_limit_ff - req_total_ff : 32'd1;
      len_a = (blocks_left_ff < {25'd0, remaining_ff}) ? blocks_left_ff[6:0] : remaining_ff;
      len_in = len_a;
      if (xfer_limit_ff != '0 && room < {25'd0, len_a}) begin
         len_in = room[6:0];
      end
   end

   always_comb begin
      total_n     = req_total_ff + {25'd0, len_ff};
      desc_n      = desc_in_req_ff + 16'd1;
      blocks_n    = blocks_left_ff - {25'd0, len_ff};
      remaining_n = remaining_ff - len_ff;
      close = (blocks_n == '0)
            || (seg_limit_ff != '0 && desc_n >= seg_limit_ff)
            || (xfer_limit_ff != '0 && total_n >= xfer_limit_ff);
      if (block_shift_ff < ShiftMin) begin
         shift = ShiftMin;
      end else if (block_shift_ff > ShiftMax) begin
         shift = ShiftMax;
      end else begin
         shift = block_shift_ff;
      end
      off_bytes = 18'({12'd0, offset_ff} << shift);
      len_bytes = 19'({12'd0, len_ff} << shift);
      lun_hi = LunHiFlat | ({2'd0, lun_id_ff[13:8]} & LunHiMask);
      lun_word = {LunAddrMethod, target_id_ff, lun_hi, lun_id_ff[7:0]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         blocks_left_ff <= '0;
         next_lba_ff    <= '0;
         req_open_ff    <= 1'b0;
         req_first_lba_ff <= '0;
         req_total_ff   <= '0;
         desc_in_req_ff <= '0;
         write_mode_ff  <= 1'b0;
         remaining_ff   <= '0;
         offset_ff      <= '0;
      end else begin
         if (cmd.load_start) begin
            next_lba_ff    <= in_lba;
            blocks_left_ff <= in_count;
            write_mode_ff  <= in_write;
            req_open_ff    <= 1'b0;
            req_total_ff   <= '0;
            desc_in_req_ff <= '0;
         end
         if (cmd.load_buffer) begin
            remaining_ff <= (in_bufblk > MaxBuf) ? MaxBuf : in_bufblk;
            offset_ff    <= '0;
         end
         if (cmd.calc && !req_open_ff) begin
            req_open_ff      <= 1'b1;
            req_first_lba_ff <= next_lba_ff;
         end
         if (cmd.emit) begin
            blocks_left_ff <= blocks_n;
            next_lba_ff    <= next_lba_ff + {57'd0, len_ff};
            remaining_ff   <= remaining_n;
            offset_ff      <= offset_ff + len_ff;
            if (close) begin
               req_open_ff    <= 1'b0;
               req_total_ff   <= '0;
               desc_in_req_ff <= '0;
            end else begin
               req_total_ff   <= total_n;
               desc_in_req_ff <= desc_n;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.calc) begin
         len_ff <= len_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_data_ff <= {1'b0, lun_word, total_n, req_first_lba_ff, close,
                         write_mode_ff, len_bytes, off_bytes};
         rsp_last_ff <= (remaining_n == '0) || (blocks_n == '0);
      end
   end

   assign stat.loop_go  = (remaining_ff != '0) && (blocks_left_ff != '0);
   assign stat.last     = (remaining_n == '0) || (blocks_n == '0);
   assign stat.out_free = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

`default_nettype wire

// File: sv/sg_transfer_request_splitter.sv
// Scatter-gather transfer request splitter: cuts buffer words of a block
// transfer into storage data descriptors. Top level joining controller and
// datapath; depends on sgtrs_pkg, sgtrs_ctrl and sgtrs_datapath.
//
// Usage: the req channel carries start and buffer words, selected by req_tuser.
// A start word loads the transfer and drops any open request; it produces no
// result and the block is ready again in the next cycle. A buffer word is
// split into descriptors, each one a word on the rsp channel, with rsp_tlast on
// the final descriptor of that buffer. The block accepts no new word until the
// buffer is fully split, but a finished descriptor may wait in the output
// register while the next one is computed.
// Sequence: each descriptor of an accepted buffer word is first sized against
// the remaining blocks and the request limit, then written to the output
// register while the request state is updated; the block is idle again after
// the last descriptor, or at once when the buffer yields nothing.
// When rsp_tready is low the sequencer holds with the next descriptor sized
// until the output register drains. Reset clears all transfer and request
// state and the configuration registers (block shift returns to 9). The
// user must write the configuration port only while the block is idle; the
// block itself does not enforce this.
`default_nettype none

module sg_transfer_request_splitter
   import sgtrs_pkg::*;
#(
   parameter int MAX_BUF_BLOCKS = 64
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     csr_we,
   input  wire logic [CsrIndexWidth-1:0] csr_index,
   input  wire logic [CsrDataWidth-1:0]  csr_wdata,
   input  wire logic                     req_tvalid,
   output logic                          req_tready,
   // Fields from bit 0: start_lba, block_count, is_write, buffer_blocks.
   input  wire logic [ReqDataWidth-1:0]  req_tdata,
   // Field: req_type.
   input  wire logic                     req_tuser,
   output logic                          rsp_tvalid,
   input  wire logic                     rsp_tready,
   // Fields from bit 0: desc_offset_bytes, desc_bytes, dir_write,
   // closes_request, request_lba, request_blocks, lun_address, zero fill.
   output logic [RspDataWidth-1:0]       rsp_tdata,
   output logic                          rsp_tlast
);

   cmd_type    cmd;
   status_type stat;

   sgtrs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tuser  (req_tuser),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   sgtrs_datapath #(
      .MAX_BUF_BLOCKS (MAX_BUF_BLOCKS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tdata  (req_tdata),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   a_emit_into_free_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> stat.out_free)
      else $error("Descriptor written over an untaken output word.");

   a_busy_after_buffer: assert property (@(posedge clock) disable iff (reset)
      cmd.load_buffer |=> !req_tready)
      else $error("Input accepted while a buffer is still being split.");

   a_nonzero_desc: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[36:18] != '0))
      else $error("Descriptor of zero length presented.");

endmodule

`default_nettype wire
